[sv/sbh_pkg.sv]
package sbh_pkg;

   localparam int PIXEL_W     = 8;
   localparam int COORD_W     = 9;
   localparam int CFG_W       = 10;
   localparam int CSR_INDEX_W = 4;
   localparam int RSP_DATA_W  = 32;

   localparam logic [PIXEL_W-1:0] VALUE_MAX = 8'd255;

   // register indexes on the configuration channel
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 4'd1;

   // one filtered pixel with the position facts the result sequencer needs
   typedef struct packed {
      logic [PIXEL_W-1:0] value;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] last_col;
      logic               interior;
      logic               at_last_col;
      logic               at_last_row;
   } sbh_item_type;

endpackage

[sv/sbh_line_ram.sv]
module sbh_line_ram #(
   parameter int DEPTH  = 512,
   parameter int DATA_W = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // read returns the old contents when both ports hit the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sbh_kernel.sv]
module sbh_kernel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        advance,
   input  logic                        full,
   input  logic [sbh_pkg::PIXEL_W-1:0] pixel,
   input  logic [sbh_pkg::PIXEL_W-1:0] top_pixel,
   output logic [sbh_pkg::PIXEL_W-1:0] value
);
   import sbh_pkg::*;

   // window: current row at c-2, c-1; row two above at c-2, c-1
   logic [PIXEL_W-1:0] cur0_ff, cur1_ff, top0_ff, top1_ff;
   logic [PIXEL_W+1:0] below, above;
   logic [PIXEL_W+2:0] diff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         cur0_ff <= '0;
         cur1_ff <= '0;
         top0_ff <= '0;
         top1_ff <= '0;
      end else if (advance) begin
         cur0_ff <= cur1_ff;
         cur1_ff <= pixel;
         top0_ff <= top1_ff;
         top1_ff <= top_pixel;
      end
   end

   always_comb begin
      below = (PIXEL_W+2)'(cur0_ff) + {1'b0, cur1_ff, 1'b0} + (PIXEL_W+2)'(pixel);
      above = (PIXEL_W+2)'(top0_ff) + {1'b0, top1_ff, 1'b0} + (PIXEL_W+2)'(top_pixel);
      diff  = {1'b0, below} - {1'b0, above};
      if (!full || diff[PIXEL_W+2]) begin
         value = '0;
      end else if (diff[PIXEL_W+1:PIXEL_W] != 2'b00) begin
         value = VALUE_MAX;
      end else begin
         value = diff[PIXEL_W-1:0];
      end
   end

endmodule

[sv/sbh_emit.sv]
module sbh_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  sbh_pkg::sbh_item_type          item,
   output logic                           in_done,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // rsp_tdata: value [7:0], out_row [16:8], out_col [25:17], zero [31:26]
   output logic [sbh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tlast: last_of_item
   output logic                           rsp_tlast,
   // rsp_tuser: frame_end
   output logic                           rsp_tuser
);
   import sbh_pkg::*;

   localparam logic [3:0] SEL_CENTER     = 4'b0001;
   localparam logic [3:0] SEL_RIGHT_EDGE = 4'b0010;
   localparam logic [3:0] SEL_BOTTOM     = 4'b0100;
   localparam logic [3:0] SEL_CORNER     = 4'b1000;

   logic [3:0]         sent_ff, sent_in;
   logic [3:0]         present, remaining, sel, rest;
   logic               slot_free, load;
   logic               valid_ff, valid_in;
   logic [PIXEL_W-1:0] value_ff, value_in;
   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic               last_ff, last_in, fend_ff, fend_in;
   logic [COORD_W-1:0] row_up, col_left;

   always_comb begin
      present   = {item.at_last_row & item.at_last_col, item.at_last_row,
                   item.at_last_col, 1'b1} & {4{item.interior}};
      remaining = present & ~sent_ff;
      sel       = remaining & (~remaining + 4'd1);
      rest      = remaining & ~sel;
      slot_free = !valid_ff || rsp_tready;
      load      = in_valid && (remaining != 4'd0) && slot_free;
      in_done   = in_valid && ((remaining == 4'd0) || (slot_free && rest == 4'd0));
      row_up    = item.row - COORD_W'(1);
      col_left  = item.col - COORD_W'(1);
   end

   always_comb begin
      sent_in  = sent_ff;
      valid_in = valid_ff;
      value_in = value_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      last_in  = last_ff;
      fend_in  = fend_ff;
      if (in_done) begin
         sent_in = '0;
      end else if (load) begin
         sent_in = sent_ff | sel;
      end
      if (load) begin
         valid_in = 1'b1;
         last_in  = (rest == 4'd0);
         fend_in  = 1'b0;
         value_in = '0;
         unique case (sel)
            SEL_CENTER: begin
               value_in = item.value;
               row_in   = row_up;
               col_in   = col_left;
            end
            SEL_RIGHT_EDGE: begin
               row_in = row_up;
               col_in = item.last_col;
            end
            SEL_BOTTOM: begin
               row_in = item.row;
               col_in = col_left;
            end
            SEL_CORNER: begin
               row_in  = item.row;
               col_in  = item.last_col;
               fend_in = 1'b1;
            end
            default: begin
               row_in = row_ff;
               col_in = col_ff;
            end
         endcase
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      last_ff  <= last_in;
      fend_ff  <= fend_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PIXEL_W - 2*COORD_W)'(0), col_ff, row_ff, value_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = fend_ff;

endmodule

[sv/sobel_horizontal_clamped.sv]
// Horizontal 3x3 Sobel filter over a raster stream of 8-bit grey pixels.
// req_*: one pixel per transaction in raster order, frame size set by the
// csr_* channel (index 0 frame width, index 1 frame height, each saturated
// to 3..MAX_WIDTH / 3..MAX_HEIGHT). Any write to either register restarts
// the frame; write only while no pixel is in flight.
// rsp_*: filtered pixels with their row and column, clamped to 0..255,
// border pixels 0. Input (r,c) yields output (r-1,c-1) once r,c >= 1, plus
// the right border at row ends and the bottom border during the last row,
// so one input gives 0 to 4 results; tlast marks the last result of an
// input, tuser the final pixel of the frame.
// Throughput: one pixel per cycle while rsp_tready stays high; an input with
// k > 1 results holds req_tready low while the single output register
// drains them. Line stores are read when a pixel is accepted; row r-1 is
// overwritten then as well, row r-2 when the pixel leaves the filter stage,
// one port each per cycle.
// Reset clears the position counters, the window and all valid flags; line
// stores hold no meaning until the first two rows have passed. When
// rsp_tready is low the result register holds and the filter stage backs up,
// dropping req_tready once it is full.
module sobel_horizontal_clamped #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata: pixel [7:0]
   input  logic [sbh_pkg::PIXEL_W-1:0]     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: value [7:0], out_row [16:8], out_col [25:17], zero [31:26]
   output logic [sbh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tlast: last_of_item
   output logic                            rsp_tlast,
   // rsp_tuser: frame_end
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sbh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sbh_pkg::CFG_W-1:0]       csr_data
);
   import sbh_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int SW = $clog2(MAX_WIDTH + 1);
   localparam int SH = $clog2(MAX_HEIGHT + 1);
   localparam int RESET_W = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;
   localparam int RESET_H = (512 > MAX_HEIGHT) ? MAX_HEIGHT : 512;

   logic [SW-1:0] width_ff, width_in, width_sat;
   logic [SH-1:0] height_ff, height_in, height_sat;
   logic          restart;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [SW-1:0] col_inc;
   logic [SH-1:0] row_inc;

   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [RW-1:0]      s1_row_ff;
   logic               s1_done, accept;

   logic [PIXEL_W-1:0] top_pixel, up_pixel, value;
   logic               full;
   sbh_item_type       item;

   // configuration
   always_comb begin
      if (csr_data < CFG_W'(3)) begin
         width_sat  = SW'(3);
      end else if (32'(csr_data) > MAX_WIDTH) begin
         width_sat  = SW'(MAX_WIDTH);
      end else begin
         width_sat  = SW'(csr_data);
      end
      if (csr_data < CFG_W'(3)) begin
         height_sat = SH'(3);
      end else if (32'(csr_data) > MAX_HEIGHT) begin
         height_sat = SH'(MAX_HEIGHT);
      end else begin
         height_sat = SH'(csr_data);
      end
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = width_sat;
               restart  = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = height_sat;
               restart   = 1'b1;
            end
            default: restart = 1'b0;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // raster position of the next input
   always_comb begin
      accept     = req_tvalid && req_tready;
      col_inc    = SW'(col_ff) + SW'(1);
      row_inc    = SH'(row_ff) + SH'(1);
      col_in     = col_ff;
      row_in     = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_inc == width_ff) begin
            col_in = '0;
            row_in = (row_inc == height_ff) ? '0 : RW'(row_inc);
         end else begin
            col_in = CW'(col_inc);
         end
      end
   end

   // filter stage: holds one pixel while the line stores deliver its column
   assign req_tready  = !s1_valid_ff || s1_done;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= SW'(RESET_W);
         height_ff   <= SH'(RESET_H);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_pixel_ff <= req_tdata;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
      end
   end

   // row r-1: read and overwritten with the new pixel on accept
   sbh_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIXEL_W)) u_previous_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up_pixel)
   );

   // row r-2: advance the column from row r-1 when the pixel leaves
   sbh_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIXEL_W)) u_older_line (
      .clock   (clock),
      .wr_en   (s1_done),
      .wr_addr (s1_col_ff),
      .wr_data (up_pixel),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (top_pixel)
   );

   assign full = (s1_row_ff > RW'(1)) && (s1_col_ff > CW'(1));

   sbh_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .clear     (restart),
      .advance   (s1_done),
      .full      (full),
      .pixel     (s1_pixel_ff),
      .top_pixel (top_pixel),
      .value     (value)
   );

   always_comb begin
      item.value       = value;
      item.row         = COORD_W'(s1_row_ff);
      item.col         = COORD_W'(s1_col_ff);
      item.last_col    = COORD_W'(width_ff - SW'(1));
      item.interior    = (s1_row_ff != '0) && (s1_col_ff != '0);
      item.at_last_col = (SW'(s1_col_ff) == width_ff - SW'(1));
      item.at_last_row = (SH'(s1_row_ff) == height_ff - SH'(1));
   end

   sbh_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .item       (item),
      .in_done    (s1_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[sv/sbh_checker.sv]
module sbh_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sbh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           rsp_tuser
);
   import sbh_pkg::*;

   // a stalled result transaction holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // the final pixel of a frame closes the results of its input
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without last_of_item");

   // top border row is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16:8] == 9'd0 |-> rsp_tdata[7:0] == 8'd0)
      else $error("nonzero value on top border");

   // left border column is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25:17] == 9'd0 |-> rsp_tdata[7:0] == 8'd0)
      else $error("nonzero value on left border");

endmodule

bind sobel_horizontal_clamped sbh_checker u_sbh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

[dv/sobel_horizontal_clamped_check.sv]
module sobel_horizontal_clamped_check #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [sbh_pkg::PIXEL_W-1:0]     req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [sbh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tlast,
   input  logic                            rsp_tuser,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [sbh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sbh_pkg::CFG_W-1:0]       csr_data,
   output int                              fail_count,
   output int                              pending_px
);
   timeunit 1ns;
   timeprecision 1ps;
   import sbh_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] value;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               last_of_pixel;
      logic               frame_end;
   } out_px_type;

   out_px_type         expected_px[$];
   logic [CFG_W-1:0]   width_reg;
   logic [CFG_W-1:0]   height_reg;
   logic [PIXEL_W-1:0] older_row [MAX_WIDTH];
   logic [PIXEL_W-1:0] prior_row [MAX_WIDTH];
   // [0],[1]: current row at c-2, c-1; [2],[3]: row two above at c-2, c-1
   logic [PIXEL_W-1:0] win [4];
   int                 row_pos;
   int                 col_pos;

   function automatic int clamp_size(logic [CFG_W-1:0] v, int hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic out_px_type make_px(logic [PIXEL_W-1:0] v, int r, int c, logic fe);
      out_px_type p;
      p.value         = v;
      p.row           = COORD_W'(r);
      p.col           = COORD_W'(c);
      p.last_of_pixel = 1'b0;
      p.frame_end     = fe;
      return p;
   endfunction

   function void restart_frame();
      for (int i = 0; i < 4; i++) win[i] = '0;
      row_pos = 0;
      col_pos = 0;
   endfunction

   function void filter_pixel(logic [PIXEL_W-1:0] px);
      int                 w;
      int                 h;
      int                 r;
      int                 c;
      int                 s;
      int                 n;
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] val;
      out_px_type         burst [4];
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      r = row_pos;
      c = col_pos;
      if (c >= w || r >= h) begin
         r = 0;
         c = 0;
      end
      top = older_row[c];
      older_row[c] = prior_row[c];
      prior_row[c] = px;

      if (r >= 1 && c >= 1) begin
         val = '0;
         if (r >= 2 && c >= 2) begin
            s = int'(win[0]) + 2 * int'(win[1]) + int'(px)
                - int'(win[2]) - 2 * int'(win[3]) - int'(top);
            if (s < 0) val = '0;
            else if (s > int'(VALUE_MAX)) val = VALUE_MAX;
            else val = PIXEL_W'(s);
         end
         n = 0;
         burst[n] = make_px(val, r - 1, c - 1, 1'b0);
         n = n + 1;
         // right border closes the row above
         if (c == w - 1) begin
            burst[n] = make_px(PIXEL_W'(0), r - 1, w - 1, 1'b0);
            n = n + 1;
         end
         // bottom border trails the last row
         if (r == h - 1) begin
            burst[n] = make_px(PIXEL_W'(0), r, c - 1, 1'b0);
            n = n + 1;
            if (c == w - 1) begin
               burst[n] = make_px(PIXEL_W'(0), r, w - 1, 1'b1);
               n = n + 1;
            end
         end
         burst[n - 1].last_of_pixel = 1'b1;
         for (int i = 0; i < n; i++) expected_px.push_back(burst[i]);
      end

      win[0] = win[1];
      win[1] = px;
      win[2] = win[3];
      win[3] = top;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endfunction

   function void check_result(out_px_type got);
      out_px_type want;
      if (expected_px.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected result value=%0d row=%0d col=%0d last=%0b end=%0b",
                     $realtime, got.value, got.row, got.col, got.last_of_pixel,
                     got.frame_end);
         return;
      end
      want = expected_px.pop_front();
      if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
          got.last_of_pixel !== want.last_of_pixel || got.frame_end !== want.frame_end)
      begin
         fail_count++;
         if (fail_count <= 10)
            $display({"%0t: result mismatch: expected value=%0d row=%0d col=%0d last=%0b",
                      " end=%0b, got value=%0d row=%0d col=%0d last=%0b end=%0b"},
                     $realtime, want.value, want.row, want.col, want.last_of_pixel,
                     want.frame_end, got.value, got.row, got.col, got.last_of_pixel,
                     got.frame_end);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = CFG_W'(512);
         height_reg = CFG_W'(512);
         for (int i = 0; i < MAX_WIDTH; i++) begin
            older_row[i] = '0;
            prior_row[i] = '0;
         end
         restart_frame();
         expected_px.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  width_reg = csr_data;
                  restart_frame();
               end
               CSR_FRAME_HEIGHT: begin
                  height_reg = csr_data;
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) filter_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_result(out_px_type'({rsp_tdata[PIXEL_W-1:0],
                                       rsp_tdata[PIXEL_W +: COORD_W],
                                       rsp_tdata[PIXEL_W+COORD_W +: COORD_W],
                                       rsp_tlast, rsp_tuser}));
      end
      pending_px = expected_px.size();
   end

endmodule

[dv/sobel_horizontal_clamped_tb.sv]
module sobel_horizontal_clamped_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 120;
   localparam int SETTLE_CYCLES   = 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int MAX_GAP         = 40;

   typedef enum int {RX_SLOW, TX_SLOW, NO_IDLE} idle_mode_type;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [sbh_pkg::PIXEL_W-1:0]         req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [sbh_pkg::RSP_DATA_W-1:0]      rsp_tdata;
   logic                                rsp_tlast;
   logic                                rsp_tuser;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [sbh_pkg::CSR_INDEX_W-1:0]     csr_index  = '0;
   logic [sbh_pkg::CFG_W-1:0]           csr_data   = '0;

   int fail_count;
   int pending_px;
   int tx_idle_pct     = 0;
   int rx_idle_pct     = 0;
   int stall_cycles    = 0;
   bit hold_off_request = 1'b0;

   always #10 clock = ~clock;

   sobel_horizontal_clamped DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sobel_horizontal_clamped_check checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending_px (pending_px)
   );

   // count cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // result side: random backpressure, plus one long hold when requested
   initial forever begin
      @(posedge clock);
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         rsp_tready <= 1'b0;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         RX_SLOW: begin
            tx_idle_pct = 7;
            rx_idle_pct = 82;
         end
         TX_SLOW: begin
            tx_idle_pct = 82;
            rx_idle_pct = 7;
         end
         default: begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
      endcase
   endtask

   // wait for every expected result, then let result-free pixels leave the pipe
   task automatic drain();
      do @(posedge clock); while (pending_px != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [sbh_pkg::CSR_INDEX_W-1:0] index,
                            logic [sbh_pkg::CFG_W-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(int frame_w, int frame_h);
      drain();
      write_reg(sbh_pkg::CSR_FRAME_WIDTH, sbh_pkg::CFG_W'(frame_w));
      write_reg(sbh_pkg::CSR_FRAME_HEIGHT, sbh_pkg::CFG_W'(frame_h));
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(logic [sbh_pkg::PIXEL_W-1:0] px);
      int gap;
      gap = 0;
      req_tdata  <= px;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_random(int frame_w, int frame_h, int count, bit with_hold);
      configure(frame_w, frame_h);
      if (with_hold) hold_off_request = 1'b1;
      repeat (count) send_pixel(sbh_pkg::PIXEL_W'($urandom_range(255)));
      req_tvalid <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // smallest frame: bright row below clamps high, then the reverse clamps
      // low; the second frame follows the wrap of the first
      set_idle(RX_SLOW);
      configure(3, 3);
      for (int f = 0; f < 2; f++)
         for (int i = 0; i < 9; i++)
            send_pixel(i < 3  ? (f == 0 ? 8'h00 : 8'hFF) :
                       i >= 6 ? (f == 0 ? 8'hFF : 8'h00) : 8'(37 * i + 90 * f));
      // leave a frame half done; the next register write restarts it
      for (int i = 0; i < 4; i++) send_pixel(8'(85 * i));
      req_tvalid <= 1'b0;

      // sizes below and above range saturate
      run_random(0, 2, 18, 1'b0);
      run_random(7, 4, 28, 1'b0);
      set_idle(TX_SLOW);
      run_random(1023, 3, 10, 1'b0);
      run_random(3, 1023, 18, 1'b0);
      set_idle(NO_IDLE);
      run_random(6, 5, 30, 1'b1);
      run_random(4, 512, 8, 1'b0);

      drain();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
